@@ rtl/core/spic_pkg.sv @@
// Shared types, constants and prefix tables for the static prefix integer codec.
// No dependencies; imported by every module under rtl/core.
package spic_pkg;

	localparam int unsigned MAG_W   = 15;
	localparam int unsigned NB_W    = 4;
	localparam int unsigned CW_W    = 21;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned VAL_W   = 16;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 48;
	localparam int unsigned OUT_TUSER_W = 2;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// one queue entry, classified by the front end
	typedef struct packed {
		logic               is_dec;
		logic               code_bit;
		logic               sign;
		logic [MAG_W-1:0]   mag;
		logic [NB_W-1:0]    nbits;
		logic               range_err;
	} item_t;

	typedef struct packed {
		logic               range_error;
		logic               is_decode;
		logic [VAL_W-1:0]   decoded_value;
		logic [LEN_W-1:0]   code_length;
		logic [CW_W-1:0]    codeword;
	} result_t;

	// bit-serial decoder phases
	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_COUNT  = 8'b0000_0010,
		PH_PRE0   = 8'b0000_0100,
		PH_PRE0B  = 8'b0000_1000,
		PH_TAILA  = 8'b0001_0000,
		PH_TAILB  = 8'b0010_0000,
		PH_TAIL1  = 8'b0100_0000,
		PH_SUFFIX = 8'b1000_0000
	} phase_t;

	// prefix bits for n = 0..15
	function automatic logic [5:0] pfx_code(input logic [NB_W-1:0] n);
		logic [5:0] c;
		case (n)
			4'd0:    c = 6'd0;
			4'd1:    c = 6'd2;
			4'd2:    c = 6'd3;
			4'd3:    c = 6'd8;
			4'd4:    c = 6'd9;
			4'd5:    c = 6'd10;
			4'd6:    c = 6'd11;
			4'd7:    c = 6'd24;
			4'd8:    c = 6'd25;
			4'd9:    c = 6'd26;
			4'd10:   c = 6'd27;
			4'd11:   c = 6'd28;
			4'd12:   c = 6'd29;
			4'd13:   c = 6'd30;
			4'd14:   c = 6'd62;
			default: c = 6'd63;
		endcase
		return c;
	endfunction

	function automatic logic [LEN_W-1:0] pfx_len(input logic [NB_W-1:0] n);
		logic [LEN_W-1:0] l;
		case (n) inside
			4'd0:           l = 5'd2;
			[4'd1:4'd2]:    l = 5'd3;
			[4'd3:4'd6]:    l = 5'd4;
			[4'd7:4'd13]:   l = 5'd5;
			default:        l = 5'd6;
		endcase
		return l;
	endfunction

endpackage

@@ rtl/core/static_prefix_integer_codec.sv @@
// Top level of the static prefix integer codec: mode register plus front end,
// queue and back end. Depends on spic_pkg, spic_front, spic_queue, spic_back.
//
// Usage:
//  - Input stream (s_axis_*): tuser selects the job, 0 = encode the 16-bit
//    value in tdata[15:0], 1 = feed code bit tdata[16] to the decoder.
//  - Output stream (m_axis_*): one word per encode, one per finished
//    codeword on the decode side. tuser[0] flags a decoded value, tuser[1]
//    flags an encode value that cannot be coded (unsigned mode, bit 15 set).
//  - cfg_wr_en/cfg_wr_data write signed_mode; write only while idle.
//  - Throughput: one input word per cycle while the receiver accepts results.
//    An accepted word is written into the queue register, and its result
//    is loaded from there into the output register.
//  - The front end classifies the word (magnitude, bit count) and pushes it
//    into a two-entry queue; the back end formats codewords and runs the
//    bit-serial decoder, loading one result register.
//  - When the receiver stalls, the result register holds and the queue
//    fills; tready drops once both queue entries are taken.
//  - Reset clears signed_mode, the decoder state, queue and output valid.
module static_prefix_integer_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,    // signed_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // value[15:0], code_bit[16], zero pad
	input  logic        s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // codeword[20:0], code_length[25:21],
	                                    // decoded_value[41:26], zero pad
	output logic [1:0]  m_axis_tuser    // is_decode[0], range_error[1]
);
	import spic_pkg::*;

	logic  mode_q;
	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	item_t push_item;
	item_t pop_item;

	// signed_mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	spic_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.mode          (mode_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	spic_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	spic_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.q_empty       (q_empty),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ rtl/core/spic_front.sv @@
// Front end: accepts input words and classifies them for the queue.
// Depends on spic_pkg (item_t).
module spic_front (
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,   // value[15:0], code_bit[16], zero pad
	input  logic                  s_axis_tuser,   // func
	input  logic                  mode,
	input  logic                  q_full,
	output logic                  q_push,
	output spic_pkg::item_t       q_item
);
	import spic_pkg::*;

	logic [VAL_W-1:0] value;
	logic [MAG_W-1:0] mag;
	logic [NB_W-1:0]  nbits;

	assign value = s_axis_tdata[VAL_W-1:0];
	assign mag   = value[VAL_W-1] ? ~value[MAG_W-1:0] : value[MAG_W-1:0];

	// significant bit count: highest set bit wins
	always_comb begin
		nbits = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag[i]) begin
				nbits = NB_W'(i + 1);
			end
		end
	end

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_item.is_dec    = (s_axis_tuser == FUNC_DECODE);
		q_item.code_bit  = s_axis_tdata[VAL_W];
		q_item.sign      = value[VAL_W-1];
		q_item.mag       = mag;
		q_item.nbits     = nbits;
		q_item.range_err = !mode && value[VAL_W-1];
	end

endmodule

@@ rtl/core/spic_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on spic_pkg (item_t).
module spic_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spic_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output spic_pkg::item_t pop_item,
	output logic            empty
);
	import spic_pkg::*;

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/spic_back.sv @@
// Back end: encode formatting, bit-serial decoder and the output register.
// Depends on spic_pkg (item_t, result_t, phase_t, prefix tables).
module spic_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mode,
	input  logic            q_empty,
	input  spic_pkg::item_t q_item,
	output logic            q_pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [47:0]     m_axis_tdata,   // codeword[20:0], code_length[25:21],
	                                        // decoded_value[41:26], zero pad
	output logic [1:0]      m_axis_tuser    // is_decode[0], range_error[1]
);
	import spic_pkg::*;

	phase_t           phase_q;
	logic [2:0]       ones_q;
	logic             tail_q;
	logic [3:0]       left_q;
	logic [MAG_W-1:0] acc_q;
	logic             sign_q;

	logic             out_valid_q;
	result_t          out_q;

	logic             take;

	// decoder next state
	phase_t           phase_d;
	logic [2:0]       ones_d;
	logic             tail_d;
	logic [3:0]       left_d;
	logic [MAG_W-1:0] acc_d;
	logic             sign_d;
	logic             dec_fire;
	logic [VAL_W-1:0] dec_val;

	// encoder
	result_t          enc_res;

	assign take  = !q_empty && (!out_valid_q || m_axis_tready);
	assign q_pop = take;

	always_comb begin
		logic       bit_in;
		logic       do_count;
		logic       bs_go;
		logic [3:0] bs_n;
		logic [2:0] oc;
		logic       emit;
		logic [MAG_W-1:0] emag;
		logic [MAG_W-1:0] sh;
		logic [3:0]       lnext;
		logic [VAL_W-1:0] v;

		bit_in   = q_item.code_bit;
		phase_d  = phase_q;
		ones_d   = ones_q;
		tail_d   = tail_q;
		left_d   = left_q;
		acc_d    = acc_q;
		sign_d   = sign_q;
		do_count = 1'b0;
		bs_go    = 1'b0;
		bs_n     = '0;
		emit     = 1'b0;
		emag     = '0;
		oc       = ones_q + 3'd1;
		sh       = {acc_q[MAG_W-2:0], bit_in};
		lnext    = left_q - 4'd1;

		case (phase_q)
			PH_START: begin
				phase_d = PH_COUNT;
				if (mode) begin
					sign_d = bit_in;
				end else begin
					do_count = 1'b1;
				end
			end
			PH_COUNT: do_count = 1'b1;
			PH_PRE0: begin
				if (!bit_in) begin
					emit = 1'b1;
				end else begin
					phase_d = PH_PRE0B;
				end
			end
			PH_PRE0B: begin
				bs_go = 1'b1;
				bs_n  = bit_in ? 4'd2 : 4'd1;
			end
			PH_TAILA: begin
				tail_d  = bit_in;
				phase_d = PH_TAILB;
			end
			PH_TAILB: begin
				bs_go = 1'b1;
				bs_n  = ((ones_q == 3'd1) ? 4'd3 : 4'd7) + {2'b00, tail_q, 1'b0}
					+ {3'b000, bit_in};
			end
			PH_TAIL1: begin
				bs_go = 1'b1;
				bs_n  = bit_in ? 4'd12 : 4'd11;
			end
			PH_SUFFIX: begin
				acc_d  = sh;
				left_d = lnext;
				if (lnext == 4'd0) begin
					emit = 1'b1;
					emag = sh;
				end
			end
			default: phase_d = PH_START;
		endcase

		// leading-ones counter
		if (do_count) begin
			if (bit_in) begin
				ones_d = oc;
				if (oc >= 3'd6) begin
					bs_go = 1'b1;
					bs_n  = 4'd15;
				end
			end else begin
				case (ones_q)
					3'd0:      phase_d = PH_PRE0;
					3'd1, 3'd2: phase_d = PH_TAILA;
					3'd3:      phase_d = PH_TAIL1;
					3'd4: begin
						bs_go = 1'b1;
						bs_n  = 4'd13;
					end
					default: begin
						bs_go = 1'b1;
						bs_n  = 4'd14;
					end
				endcase
			end
		end

		// start of suffix, or a value with no suffix bits
		if (bs_go) begin
			if (bs_n <= 4'd1) begin
				emit = 1'b1;
				emag = MAG_W'(bs_n);
			end else begin
				acc_d   = MAG_W'(1);
				left_d  = bs_n - 4'd1;
				phase_d = PH_SUFFIX;
			end
		end

		v = {1'b0, emag};
		if (sign_q) begin
			v = ~v;
		end
		dec_val  = v;
		dec_fire = emit;

		if (emit) begin
			phase_d = PH_START;
			ones_d  = '0;
			tail_d  = 1'b0;
			left_d  = '0;
			acc_d   = '0;
			sign_d  = 1'b0;
		end
	end

	// encode: prefix, then the bits below the leading one, sign bit in front
	always_comb begin
		logic [CW_W-1:0]  cw;
		logic [LEN_W-1:0] len;
		logic [3:0]       sft;

		sft = q_item.nbits - 4'd1;
		cw  = CW_W'(pfx_code(q_item.nbits));
		len = pfx_len(q_item.nbits);
		if (q_item.nbits >= 4'd2) begin
			cw  = (cw << sft) | (CW_W'(q_item.mag) & ((CW_W'(1) << sft) - CW_W'(1)));
			len = len + LEN_W'(sft);
		end
		if (mode) begin
			cw  = cw | (CW_W'(q_item.sign) << len);
			len = len + LEN_W'(1);
		end

		enc_res.is_decode     = 1'b0;
		enc_res.decoded_value = '0;
		if (q_item.range_err) begin
			enc_res.codeword    = '0;
			enc_res.code_length = '0;
			enc_res.range_error = 1'b1;
		end else begin
			enc_res.codeword    = cw;
			enc_res.code_length = len;
			enc_res.range_error = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ones_q  <= '0;
			tail_q  <= 1'b0;
			left_q  <= '0;
			acc_q   <= '0;
			sign_q  <= 1'b0;
		end else if (take && q_item.is_dec) begin
			phase_q <= phase_d;
			ones_q  <= ones_d;
			tail_q  <= tail_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			sign_q  <= sign_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && (!q_item.is_dec || dec_fire)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (q_item.is_dec) begin
				out_q.codeword      <= '0;
				out_q.code_length   <= '0;
				out_q.decoded_value <= dec_val;
				out_q.is_decode     <= 1'b1;
				out_q.range_error   <= 1'b0;
			end else begin
				out_q <= enc_res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.decoded_value, out_q.code_length, out_q.codeword};
	assign m_axis_tuser  = {out_q.range_error, out_q.is_decode};

endmodule
